FILE: rtl/core/assert_macros.svh
// Assertion shorthands shared by the root directory scanner RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every clock edge outside reset.
`define F16RD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check at every clock edge, reset included.
`define F16RD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/f16rd_pkg.sv
// Shared types, constants and helpers for the FAT16 root directory scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package f16rd_pkg;

  localparam int SECTOR_BYTES       = 512;
  localparam int ENTRY_BYTES        = 32;
  localparam int ENTRIES_PER_SECTOR = SECTOR_BYTES / ENTRY_BYTES;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_END_MARK  = 8'h00;
  localparam logic [7:0] BYTE_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam int         ATTR_VOLUME_BIT = 3;

  localparam logic [4:0] POS_LAST = 5'(ENTRY_BYTES - 1);

  typedef enum logic [1:0] {
    ST_LISTED    = 2'd0,
    ST_MATCHED   = 2'd1,
    ST_END_MARK  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SEARCH_MODE = 2'd0,
    CFG_WANT_NAME   = 2'd1,
    CFG_WANT_EXT    = 2'd2,
    CFG_ROOT_COUNT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        search_mode;
    logic [63:0] want_name;
    logic [23:0] want_ext;
    logic [16:0] entry_limit;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] name_raw;
    logic [23:0] ext_raw;
    logic [7:0]  attributes;
    logic [15:0] first_cluster;
    logic [31:0] file_size;
  } rec_t;

  // Entry count rounded up to whole sectors.
  function automatic logic [16:0] entry_limit(input logic [15:0] root_count);
    logic [16:0] sum;
    sum = {1'b0, root_count} + 17'(ENTRIES_PER_SECTOR - 1);
    return sum & ~17'(ENTRIES_PER_SECTOR - 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/f16rd_front.sv
// Front end: assembles 32-byte directory entries and classifies each one.
// Depends on f16rd_pkg; pushes result records into f16rd_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module f16rd_front
  import f16rd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       acc,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_req,
  output logic            push,
  output rec_t            rec
);

  logic [4:0]  pos_r,  pos_nxt;
  logic [16:0] seen_r, seen_nxt;
  logic        done_r, done_nxt;
  logic [63:0] name_r, name_nxt;
  logic [23:0] ext_r,  ext_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [15:0] clus_r, clus_nxt;
  logic [31:0] size_r, size_nxt;

  logic [4:0]  pos_eff;
  logic [16:0] seen_eff;
  logic        run, exhaust, capture, last_byte;
  logic [7:0]  first_byte;
  logic        skip, match;

  always_comb begin
    pos_eff  = start_req ? 5'd0 : pos_r;
    seen_eff = start_req ? 17'd0 : seen_r;
    run      = acc && (start_req || !done_r);
    exhaust  = run && (pos_eff == 5'd0) && (seen_eff >= cfg.entry_limit);
    capture  = run && !exhaust;
    last_byte = capture && (pos_eff == POS_LAST);

    name_nxt = name_r;
    ext_nxt  = ext_r;
    attr_nxt = attr_r;
    clus_nxt = clus_r;
    size_nxt = size_r;
    if (capture) begin
      case (pos_eff) inside
        [5'd0:5'd7]:   name_nxt = {name_r[55:0], data_byte};
        [5'd8:5'd10]:  ext_nxt  = {ext_r[15:0], data_byte};
        5'd11:         attr_nxt = data_byte;
        5'd26:         clus_nxt = {clus_r[15:8], data_byte};
        5'd27:         clus_nxt = {data_byte, clus_r[7:0]};
        [5'd28:5'd31]: size_nxt = {data_byte, size_r[31:8]};
        default:       ;
      endcase
    end

    first_byte = name_nxt[63:56];
    skip  = (first_byte == BYTE_DELETED) || (attr_nxt == ATTR_LONG_NAME) ||
            attr_nxt[ATTR_VOLUME_BIT];
    match = (name_nxt == cfg.want_name) && (ext_nxt == cfg.want_ext);

    push = exhaust ||
           (last_byte && ((first_byte == BYTE_END_MARK) ||
                          (!skip && (!cfg.search_mode || match))));

    if (exhaust) begin
      rec = '0;
      rec.status = ST_EXHAUSTED;
    end else begin
      rec.name_raw      = name_nxt;
      rec.ext_raw       = ext_nxt;
      rec.attributes    = attr_nxt;
      rec.first_cluster = clus_nxt;
      rec.file_size     = size_nxt;
      if (first_byte == BYTE_END_MARK) begin
        rec.status = ST_END_MARK;
      end else if (cfg.search_mode) begin
        rec.status = ST_MATCHED;
      end else begin
        rec.status = ST_LISTED;
      end
    end

    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (acc && start_req) begin
      pos_nxt  = 5'd0;
      seen_nxt = 17'd0;
      done_nxt = 1'b0;
    end
    if (exhaust) begin
      done_nxt = 1'b1;
    end
    if (capture) begin
      pos_nxt = pos_eff + 5'd1;
    end
    if (last_byte) begin
      seen_nxt = seen_eff + 17'd1;
      // A search hit or an end mark closes the scan.
      if (push && (rec.status != ST_LISTED)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 5'd0;
      seen_r <= 17'd0;
      done_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r <= name_nxt;
    ext_r  <= ext_nxt;
    attr_r <= attr_nxt;
    clus_r <= clus_nxt;
    size_r <= size_nxt;
  end

  `F16RD_ASSERT_CLK(a_push_needs_accept, push |-> acc, "result pushed without an accepted byte")
  `F16RD_ASSERT_CLK(a_idle_no_push, (done_r && !start_req) |-> !push, "result pushed while idle")
  `F16RD_ASSERT_CLK(a_final_sets_done, (push && (rec.status != ST_LISTED)) |=> done_r,
                    "scan not closed after a final result")

endmodule

`default_nettype wire

FILE: rtl/core/f16rd_queue.sv
// Short result queue between the entry front end and the output stage.
// Depends on f16rd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module f16rd_queue
  import f16rd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t push_rec,
  input  wire logic pop,
  output rec_t      head_rec,
  output logic      full,
  output logic      empty
);

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    full       = (count_r == QCNT_W'(QUEUE_DEPTH));
    empty      = (count_r == '0);
    head_rec   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  `F16RD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (count_r == '0), "queue not empty after reset")
  `F16RD_ASSERT_CLK(a_no_overflow, push |-> !full, "push into a full queue")
  `F16RD_ASSERT_CLK(a_no_underflow, pop |-> !empty, "pop from an empty queue")
  `F16RD_ASSERT_CLK(a_count_up, (push && !pop) |=> (count_r == QCNT_W'($past(count_r) + 1'b1)),
                    "queue count lost a push")

endmodule

`default_nettype wire

FILE: rtl/core/f16rd_back.sv
// Output stage: pulls records from the queue into the result register.
// Depends on f16rd_pkg; fed by f16rd_queue.
`timescale 1ns / 1ps
`default_nettype none

module f16rd_back
  import f16rd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire rec_t head_rec,
  output logic      pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output rec_t      out_rec
);

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r;

  always_comb begin
    // Refill whenever the register is free or its record leaves this cycle.
    pop = !q_empty && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec_r <= head_rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

`default_nettype wire

FILE: rtl/core/fat16_root_directory_scanner_core.sv
// FAT16 root directory scanner. Takes one directory byte per cycle while
// in_stall is low: each accepted byte updates the entry assembly registers
// in the cycle it arrives, and the entry's last byte decides whether it is
// reported. A result is written into a two-deep record queue and from there
// into an output register, which raises out_valid; in_stall is raised only
// while the queue holds two records the output side has not taken.
// Configuration writes are always ready and must only be issued while no
// scan is producing results.
`timescale 1ns / 1ps
`default_nettype none

module fat16_root_directory_scanner_core
  import f16rd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [63:0]      out_name_raw,
  output logic [23:0]      out_ext_raw,
  output logic [7:0]       out_attributes,
  output logic [15:0]      out_first_cluster,
  output logic [31:0]      out_file_size,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic        search_mode_r;
  logic [63:0] want_name_r;
  logic [23:0] want_ext_r;
  logic [15:0] root_count_r;
  cfg_t        cfg;

  logic acc, push, pop, q_full, q_empty;
  rec_t push_rec, head_rec, out_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_mode_r <= 1'b0;
      want_name_r   <= 64'd0;
      want_ext_r    <= 24'd0;
      root_count_r  <= 16'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEARCH_MODE: search_mode_r <= cfg_data[0];
        CFG_WANT_NAME:   want_name_r   <= cfg_data;
        CFG_WANT_EXT:    want_ext_r    <= cfg_data[23:0];
        CFG_ROOT_COUNT:  root_count_r  <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    cfg.search_mode = search_mode_r;
    cfg.want_name   = want_name_r;
    cfg.want_ext    = want_ext_r;
    cfg.entry_limit = entry_limit(root_count_r);
  end

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  f16rd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .acc       (acc),
    .data_byte (in_data_byte),
    .start_req (in_start_req),
    .push      (push),
    .rec       (push_rec)
  );

  f16rd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  f16rd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign out_status        = out_rec.status;
  assign out_name_raw      = out_rec.name_raw;
  assign out_ext_raw       = out_rec.ext_raw;
  assign out_attributes    = out_rec.attributes;
  assign out_first_cluster = out_rec.first_cluster;
  assign out_file_size     = out_rec.file_size;

endmodule

`default_nettype wire

FILE: test/tb_fat16_root_directory_scanner_core.sv
`timescale 1ns / 1ps
// Self-checking bench for fat16_root_directory_scanner_core: directed and random directory
// byte streams, every output transfer checked against a cycle-free scan predictor.
// Depends on f16rd_pkg and the core RTL only.
module tb_fat16_root_directory_scanner_core;
  import f16rd_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [63:0] NAME_README  = 64'h5245_4144_4D45_2020;
  localparam logic [23:0] EXT_TXT      = 24'h545854;
  localparam logic [7:0]  VOLUME_MASK  = 8'h1 << ATTR_VOLUME_BIT;

  // Sender 17% / receiver 62% gaps, then swapped, then no gaps at all.
  typedef enum logic [1:0] {PACE_RECV_SLOW, PACE_SEND_SLOW, PACE_NONE} pace_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } dir_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_start_req = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_name_raw;
  logic [23:0] out_ext_raw;
  logic [7:0]  out_attributes;
  logic [15:0] out_first_cluster;
  logic [31:0] out_file_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_SEARCH_MODE;
  logic [63:0] cfg_data = '0;

  pace_t       pace = PACE_RECV_SLOW;

  // Register copies, at their reset values.
  logic        cfg_search_q = 1'b0;
  logic [63:0] cfg_name_q = '0;
  logic [23:0] cfg_ext_q = '0;
  logic [15:0] cfg_root_q = 16'd512;

  // Scan state of the predictor.
  logic [4:0]  scan_pos = '0;
  logic [16:0] scan_seen = '0;
  logic [63:0] scan_name = '0;
  logic [23:0] scan_ext = '0;
  logic [7:0]  scan_attr = '0;
  logic [15:0] scan_cluster = '0;
  logic [31:0] scan_size = '0;
  logic        scan_idle = 1'b1;

  dir_byte_t   byte_q[$];
  rec_t        rec_q[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          errors = 0;
  int          cycles = 0;

  logic        hold_go = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  fat16_root_directory_scanner_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_req     (in_start_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_name_raw     (out_name_raw),
    .out_ext_raw      (out_ext_raw),
    .out_attributes   (out_attributes),
    .out_first_cluster(out_first_cluster),
    .out_file_size    (out_file_size),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic rec_t snapshot(input status_t st);
    rec_t r;
    r.status        = st;
    r.name_raw      = scan_name;
    r.ext_raw       = scan_ext;
    r.attributes    = scan_attr;
    r.first_cluster = scan_cluster;
    r.file_size     = scan_size;
    return r;
  endfunction

  // Advance the scan by one directory byte and queue the record it reports, if any.
  task automatic scan_byte(input logic [7:0] b, input logic start);
    int         lim;
    rec_t       r;
    logic [7:0] lead;
    if (start) begin
      scan_pos  = '0;
      scan_seen = '0;
      scan_idle = 1'b0;
    end
    if (scan_idle) return;
    lim = ((int'(cfg_root_q) * ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES)
          * ENTRIES_PER_SECTOR;
    if (scan_pos == 5'd0 && int'(scan_seen) >= lim) begin
      // byte is not consumed: the table ran out before it
      scan_idle = 1'b1;
      r = '0;
      r.status = ST_EXHAUSTED;
      rec_q.push_back(r);
      return;
    end
    if (scan_pos < 5'd8) scan_name = {scan_name[55:0], b};
    else if (scan_pos < 5'd11) scan_ext = {scan_ext[15:0], b};
    else if (scan_pos == 5'd11) scan_attr = b;
    else if (scan_pos == 5'd26) scan_cluster = {8'h00, b};
    else if (scan_pos == 5'd27) scan_cluster = {b, scan_cluster[7:0]};
    else if (scan_pos >= 5'd28) scan_size = {b, scan_size[31:8]};
    if (scan_pos != POS_LAST) begin
      scan_pos = scan_pos + 5'd1;
      return;
    end
    scan_pos  = '0;
    scan_seen = scan_seen + 17'd1;
    lead = scan_name[63:56];
    if (lead == BYTE_END_MARK) begin
      scan_idle = 1'b1;
      rec_q.push_back(snapshot(ST_END_MARK));
    end else if (lead == BYTE_DELETED || scan_attr == ATTR_LONG_NAME ||
                 scan_attr[ATTR_VOLUME_BIT]) begin
      // hidden entry: drop
    end else if (cfg_search_q) begin
      if (scan_name == cfg_name_q && scan_ext == cfg_ext_q) begin
        scan_idle = 1'b1;
        rec_q.push_back(snapshot(ST_MATCHED));
      end
    end else begin
      rec_q.push_back(snapshot(ST_LISTED));
    end
  endtask

  task automatic check_field(input string fld, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $error("%s expected %h got %h", fld, want, got);
    end
  endtask

  // Byte feeder: predict on each input transfer, hold while stalled.
  always @(posedge clk) begin : feed_p
    dir_byte_t nxt;
    int        send_pct;
    send_pct = (pace == PACE_RECV_SLOW) ? 17 : (pace == PACE_SEND_SLOW) ? 62 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_start_req);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && !($urandom_range(99) < send_pct)) begin
          nxt = byte_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_start_req <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Record checker and receiver back-pressure.
  always @(posedge clk) begin : watch_p
    rec_t exp_rec;
    int   recv_pct;
    recv_pct = (pace == PACE_RECV_SLOW) ? 62 : (pace == PACE_SEND_SLOW) ? 17 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rec_q.size() == 0) begin
          errors++;
          $error("record with no expectation: status %0d name %h", out_status, out_name_raw);
        end else begin
          exp_rec = rec_q.pop_front();
          check_field("status", exp_rec.status, out_status);
          check_field("name_raw", exp_rec.name_raw, out_name_raw);
          check_field("ext_raw", exp_rec.ext_raw, out_ext_raw);
          check_field("attributes", exp_rec.attributes, out_attributes);
          check_field("first_cluster", exp_rec.first_cluster, out_first_cluster);
          check_field("file_size", exp_rec.file_size, out_file_size);
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog_p
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SEARCH_MODE: cfg_search_q = val[0];
      CFG_WANT_NAME:   cfg_name_q   = val;
      CFG_WANT_EXT:    cfg_ext_q    = val[23:0];
      CFG_ROOT_COUNT:  cfg_root_q   = val[15:0];
      default:         ;
    endcase
  endtask

  // Wait until every byte is taken and every record has arrived, then let the pipe empty.
  task automatic drain();
    while (bytes_taken != bytes_queued || rec_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    byte_q.push_back({b, start});
    bytes_queued++;
  endtask

  task automatic push_junk(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic push_entry(input logic [63:0] nm, input logic [23:0] ex, input logic [7:0] at,
                            input logic [15:0] cl, input logic [31:0] sz, input logic start);
    for (int i = 0; i < 8; i++) push_byte(nm[63 - 8 * i -: 8], start && i == 0);
    for (int i = 0; i < 3; i++) push_byte(ex[23 - 8 * i -: 8], 1'b0);
    push_byte(at, 1'b0);
    push_junk(14);
    push_byte(cl[7:0], 1'b0);
    push_byte(cl[15:8], 1'b0);
    for (int i = 0; i < 4; i++) push_byte(sz[8 * i +: 8], 1'b0);
  endtask

  function automatic logic [63:0] rand_name();
    logic [63:0] n;
    n = {$urandom, $urandom};
    while (n[63:56] == BYTE_END_MARK || n[63:56] == BYTE_DELETED) n[63:56] = 8'($urandom);
    return n;
  endfunction

  function automatic logic [7:0] visible_attr();
    return 8'($urandom) & ~VOLUME_MASK;
  endfunction

  // One scan of mostly well-formed entries with hidden ones, noise and restarts mixed in.
  task automatic rand_scan(input int n_ent);
    logic        st;
    int          pick;
    int          k;
    logic [63:0] nm;
    logic [23:0] ex;
    logic [7:0]  at;
    st = 1'b1;
    for (int i = 0; i < n_ent; i++) begin
      pick = $urandom_range(99);
      nm = rand_name();
      ex = 24'($urandom);
      at = visible_attr();
      if (pick < 25 && cfg_search_q) begin
        nm = cfg_name_q;
        ex = cfg_ext_q;
      end else if (pick < 32 && cfg_search_q) begin
        nm = cfg_name_q;
        ex = cfg_ext_q;
        k = $urandom_range(87);
        if (k < 64) nm[k] = ~nm[k];
        else ex[k - 64] = ~ex[k - 64];
      end else if (pick < 40) begin
        nm[63:56] = BYTE_DELETED;
      end else if (pick < 47) begin
        at = ATTR_LONG_NAME;
      end else if (pick < 53) begin
        at = at | VOLUME_MASK;
      end else if (pick < 58) begin
        push_byte(8'($urandom), st);
        push_junk(31);
        st = 1'b0;
        continue;
      end else if (pick < 62) begin
        // cut the entry short; the next one restarts the scan
        push_byte(8'($urandom), st);
        push_junk($urandom_range(30));
        st = 1'b1;
        continue;
      end else if (pick < 66) begin
        push_entry({BYTE_END_MARK, nm[55:0]}, ex, at, 16'($urandom), $urandom, st);
        push_junk($urandom_range(40));
        return;
      end
      push_entry(nm, ex, at, 16'($urandom), $urandom, st);
      st = 1'b0;
    end
  endtask

  task automatic rand_phase(input pace_t p, input int budget);
    int mark;
    int pick;
    pace <= p;
    mark = bytes_queued;
    while (bytes_queued - mark < budget) begin
      write_reg(CFG_SEARCH_MODE, 64'($urandom_range(1)));
      write_reg(CFG_WANT_NAME, rand_name());
      write_reg(CFG_WANT_EXT, 64'($urandom_range(24'hFFFFFF)));
      pick = $urandom_range(99);
      if (pick < 10) write_reg(CFG_ROOT_COUNT, 64'($urandom_range(2)));
      else if (pick < 75) write_reg(CFG_ROOT_COUNT, 64'($urandom_range(40, 1)));
      else write_reg(CFG_ROOT_COUNT, 64'($urandom_range(16'hFFFF)));
      repeat ($urandom_range(2, 1)) rand_scan($urandom_range(4, 1));
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Listing: field extremes, each hidden kind, a directory, then the end marker.
    write_reg(CFG_SEARCH_MODE, 64'd0);
    write_reg(CFG_WANT_NAME, NAME_README);
    write_reg(CFG_WANT_EXT, EXT_TXT);
    write_reg(CFG_ROOT_COUNT, 64'd3);
    push_entry('1, '1, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    push_entry(64'h0100_0000_0000_0000, '0, 8'h00, 16'h0000, 32'h0, 1'b0);
    push_entry({BYTE_DELETED, NAME_README[55:0]}, EXT_TXT, 8'h20, 16'h0003, 32'h40, 1'b0);
    push_entry(NAME_README, EXT_TXT, ATTR_LONG_NAME, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    push_entry(NAME_README, EXT_TXT, VOLUME_MASK, 16'h0000, 32'h0, 1'b0);
    push_entry(NAME_README, EXT_TXT, 8'h10, 16'h0005, 32'h0, 1'b0);
    push_entry(NAME_README, EXT_TXT, 8'hF7, 16'h8001, 32'h8000_0001, 1'b0);
    push_entry('0, '0, 8'h00, 16'h1234, 32'h0000_0200, 1'b0);
    push_junk(10);
    // restart in the middle of an entry
    push_byte(8'h41, 1'b1);
    push_junk(9);
    push_entry(NAME_README, EXT_TXT, 8'h01, 16'h0002, 32'h10, 1'b1);
    push_entry('0, '0, 8'h00, 16'h0000, 32'h0, 1'b0);
    drain();

    // Empty table: the start byte itself reports exhaustion.
    write_reg(CFG_ROOT_COUNT, 64'd0);
    push_byte(8'h41, 1'b1);
    push_junk(5);
    drain();

    // One entry rounds up to a full sector; the entry after it runs out.
    // Hold the receiver off meanwhile so the queue fills and the input stalls.
    write_reg(CFG_ROOT_COUNT, 64'd1);
    hold_go <= 1'b1;
    for (int i = 0; i < ENTRIES_PER_SECTOR; i++)
      push_entry(rand_name(), 24'($urandom), visible_attr(), 16'($urandom), $urandom, i == 0);
    push_byte(8'h52, 1'b0);
    push_junk(8);
    drain();

    // Search: near misses and hidden copies first, then a directory that matches.
    write_reg(CFG_SEARCH_MODE, 64'd1);
    write_reg(CFG_ROOT_COUNT, 64'hFFFF);
    push_entry(rand_name(), EXT_TXT, 8'h00, 16'h0007, 32'h99, 1'b1);
    push_entry(NAME_README, 24'h545855, 8'h00, 16'h0008, 32'h1, 1'b0);
    push_entry({BYTE_DELETED, NAME_README[55:0]}, EXT_TXT, 8'h00, 16'h0009, 32'h2, 1'b0);
    push_entry(NAME_README, EXT_TXT, ATTR_LONG_NAME, 16'h000A, 32'h3, 1'b0);
    push_entry(NAME_README, EXT_TXT, 8'h10, 16'h000B, 32'h4, 1'b0);
    push_junk(6);
    push_entry(rand_name(), 24'($urandom), 8'h00, 16'h0001, 32'h5, 1'b1);
    push_entry('0, '0, 8'h00, 16'h0000, 32'h0, 1'b0);
    drain();

    write_reg(CFG_WANT_NAME, '1);
    write_reg(CFG_WANT_EXT, 64'hFF_FFFF);
    push_entry('1, '1, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    drain();

    rand_phase(PACE_SEND_SLOW, 50);
    rand_phase(PACE_NONE, 50);

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: fat16_root_directory_scanner_core.f
+incdir+rtl/core
rtl/core/f16rd_pkg.sv
rtl/core/f16rd_front.sv
rtl/core/f16rd_queue.sv
rtl/core/f16rd_back.sv
rtl/core/fat16_root_directory_scanner_core.sv
test/tb_fat16_root_directory_scanner_core.sv
